FILE: rtl/msps_pkg.sv
// ============================================================================
// msps_pkg
// Shared types and constants for the multi-channel servo pulse sequencer.
// ============================================================================
package msps_pkg;

    // Channel count and angle scale
    localparam int NUM_CHANNELS = 8;
    localparam int FULL_ANGLE   = 180;
    localparam int SLOT_W       = $clog2(NUM_CHANNELS);
    localparam int LINES_W      = 8;

    // Field widths
    localparam int ACT_W    = 4;
    localparam int PULSE_W  = 12;
    localparam int PERIOD_W = 16;
    localparam int CHAN_W   = 3;
    localparam int ANGLE_W  = 8;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;

    // Stream payload layout
    localparam int IN_ANGLE_LSB   = CHAN_W;
    localparam int OUT_SLOT_LSB   = LINES_W;
    localparam int OUT_START_BIT  = LINES_W + CHAN_W;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Reciprocal divide by FULL_ANGLE, exact for any product below 2**PROD_W
    localparam int PROD_W    = ANGLE_W + PULSE_W;
    localparam int DIV_SHIFT = PROD_W + $clog2(FULL_ANGLE);
    localparam int DIV_MULT  = ((2 ** DIV_SHIFT) + FULL_ANGLE - 1) / FULL_ANGLE;
    localparam int MULT_W    = $clog2(DIV_MULT + 1);

    // Reset values
    localparam logic [ACT_W-1:0]    RST_ACTIVE = '0;
    localparam logic [PULSE_W-1:0]  RST_MIN    = 12'd700;
    localparam logic [PULSE_W-1:0]  RST_MAX    = 12'd2400;
    localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd2500;
    localparam logic [PULSE_W-1:0]  WIDTH_MAX  = '1;

    // Register map (word index)
    typedef enum logic [1:0] {
        REG_ACTIVE = 2'd0,
        REG_MIN    = 2'd1,
        REG_MAX    = 2'd2,
        REG_PERIOD = 2'd3
    } t_reg_idx;

    // Request kinds carried in tuser
    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_ANGLE = 1'b1
    } t_req;

endpackage

FILE: rtl/multi_servo_pulse_sequencer.sv
// ============================================================================
// multi_servo_pulse_sequencer
// Time-multiplexed servo pulse generator: one slot per channel, pulse width
// from a per-channel angle held in a small angle memory.
// ============================================================================
//
//  Channel   Direction  Payload
//  --------  ---------  ------------------------------------------------------
//  s_*       in         tuser: req_type; tdata: channel, angle
//  m_*       out        tdata: pulse_lines, current_slot, slot_start
//  APB       in/out     active_channels, min/max pulse ticks, slot period
//
//  One request accepted per cycle while the result side does not stall, one
//  result per request; four register stages, the last holding the result. The width
//  path (angle memory read, span multiply, reciprocal multiply, add and clamp)
//  sets the pipeline depth.
//  Reset is synchronous; angle entries read as zero until written (per-entry
//  valid bits), so no clearing pass is needed.
//  A stalled result freezes the whole pipeline; s_tready follows m_tready.
//
module multi_servo_pulse_sequencer
    import msps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // [2:0] channel, [10:3] angle
    input  logic [0:0]        s_tuser,   // [0] req_type
    // Result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [7:0] pulse_lines, [10:8] current_slot,
                                         // [11] slot_start
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [ACT_W-1:0]    r_active;
    logic [PULSE_W-1:0]  r_min;
    logic [PULSE_W-1:0]  r_max;
    logic [PERIOD_W-1:0] r_period;
    logic                w_cfg_wr;
    t_reg_idx            w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= RST_ACTIVE;
            r_min    <= RST_MIN;
            r_max    <= RST_MAX;
            r_period <= RST_PERIOD;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_ACTIVE: r_active <= pwdata[ACT_W-1:0];
                REG_MIN:    r_min    <= pwdata[PULSE_W-1:0];
                REG_MAX:    r_max    <= pwdata[PULSE_W-1:0];
                REG_PERIOD: r_period <= pwdata[PERIOD_W-1:0];
                default:    r_active <= r_active;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (w_cfg_idx)
            REG_ACTIVE: prdata = DATA_W'(r_active);
            REG_MIN:    prdata = DATA_W'(r_min);
            REG_MAX:    prdata = DATA_W'(r_max);
            REG_PERIOD: prdata = DATA_W'(r_period);
            default:    prdata = '0;
        endcase
    end

    // Derived settings: zero period acts as one tick, negative span as zero
    logic [PERIOD_W-1:0] w_eff_period;
    logic [PULSE_W-1:0]  w_span;

    assign w_eff_period = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign w_span       = (r_max > r_min) ? (r_max - r_min) : '0;

    // ------------------------------------------------------------------------
    // Input decode and pipeline enable
    // ------------------------------------------------------------------------
    logic               w_en;
    logic               w_in_acc;
    logic               w_in_tick;
    logic [CHAN_W-1:0]  w_in_chan;
    logic [ANGLE_W-1:0] w_in_angle;
    logic [ANGLE_W-1:0] w_angle_sat;
    logic               r_out_valid;

    assign w_en        = !r_out_valid || m_tready;
    assign s_tready    = w_en;
    assign w_in_acc    = s_tvalid && w_en;
    assign w_in_tick   = (t_req'(s_tuser[0]) == REQ_TICK);
    assign w_in_chan   = s_tdata[CHAN_W-1:0];
    assign w_in_angle  = s_tdata[IN_ANGLE_LSB +: ANGLE_W];
    assign w_angle_sat = (int'(w_in_angle) > FULL_ANGLE) ? ANGLE_W'(FULL_ANGLE) : w_in_angle;

    // ------------------------------------------------------------------------
    // Slot timing state
    // ------------------------------------------------------------------------
    logic [SLOT_W-1:0]   r_slot;
    logic [PERIOD_W-1:0] r_cnt;
    logic [PERIOD_W:0]   w_cnt_inc;
    logic                w_slot_end;

    assign w_cnt_inc  = {1'b0, r_cnt} + (PERIOD_W+1)'(1);
    assign w_slot_end = (w_cnt_inc >= {1'b0, w_eff_period});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_cnt  <= '0;
        end else if (w_in_acc && w_in_tick) begin
            if (w_slot_end) begin
                r_cnt  <= '0;
                r_slot <= (int'(r_slot) == NUM_CHANNELS - 1) ? '0 : r_slot + SLOT_W'(1);
            end else begin
                r_cnt  <= w_cnt_inc[PERIOD_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Angle memory: written by angle requests, read for the current slot
    // ------------------------------------------------------------------------
    logic [ANGLE_W-1:0]    r_angle_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_angle_vld;
    logic                  w_angle_wr;
    logic [SLOT_W-1:0]     w_wr_idx;

    assign w_angle_wr = w_in_acc && !w_in_tick && (int'(w_in_chan) < NUM_CHANNELS);
    assign w_wr_idx   = w_in_chan[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_angle_wr) begin
            r_angle_mem[w_wr_idx] <= w_angle_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_vld <= '0;
        end else if (w_angle_wr) begin
            r_angle_vld[w_wr_idx] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: memory read, request control captured
    // ------------------------------------------------------------------------
    logic                r_v1, r_tick1, r_start1, r_angv1;
    logic [SLOT_W-1:0]   r_slot1;
    logic [PERIOD_W-1:0] r_cnt1;
    logic [ANGLE_W-1:0]  r_ang1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tick1  <= w_in_tick;
            r_start1 <= (r_cnt == '0);
            r_slot1  <= r_slot;
            r_cnt1   <= r_cnt;
            r_ang1   <= r_angle_mem[r_slot];
            r_angv1  <= r_angle_vld[r_slot];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: angle times span
    // ------------------------------------------------------------------------
    logic                r_v2, r_tick2, r_start2;
    logic [SLOT_W-1:0]   r_slot2;
    logic [PERIOD_W-1:0] r_cnt2;
    logic [PROD_W-1:0]   r_prod2;
    logic [ANGLE_W-1:0]  w_ang1;

    assign w_ang1 = r_angv1 ? r_ang1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tick2  <= r_tick1;
            r_start2 <= r_start1;
            r_slot2  <= r_slot1;
            r_cnt2   <= r_cnt1;
            r_prod2  <= PROD_W'(w_ang1) * PROD_W'(w_span);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: divide by full angle through a reciprocal multiply
    // ------------------------------------------------------------------------
    logic                       r_v3, r_tick3, r_start3;
    logic [SLOT_W-1:0]          r_slot3;
    logic [PERIOD_W-1:0]        r_cnt3;
    logic [PULSE_W-1:0]         r_q3;
    logic [PROD_W+MULT_W-1:0]   w_recip_prod;

    assign w_recip_prod = (PROD_W+MULT_W)'(r_prod2) * (PROD_W+MULT_W)'(DIV_MULT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tick3  <= r_tick2;
            r_start3 <= r_start2;
            r_slot3  <= r_slot2;
            r_cnt3   <= r_cnt2;
            r_q3     <= w_recip_prod[DIV_SHIFT +: PULSE_W];
        end
    end

    // ------------------------------------------------------------------------
    // Output stage: width add and clamp, pulse compare, result register
    // ------------------------------------------------------------------------
    logic [PULSE_W:0]    w_sum;
    logic [PULSE_W-1:0]  w_wsat;
    logic [PULSE_W-1:0]  w_width;
    logic [PULSE_W-1:0]  w_width_use;
    logic                w_slot_act;
    logic [LINES_W-1:0]  w_lines;
    logic [PULSE_W-1:0]  r_width;
    logic [LINES_W-1:0]  r_out_lines;
    logic [SLOT_W-1:0]   r_out_slot;
    logic                r_out_start;

    assign w_sum   = {1'b0, r_min} + {1'b0, r_q3};
    assign w_wsat  = w_sum[PULSE_W] ? WIDTH_MAX : w_sum[PULSE_W-1:0];
    assign w_width = (PERIOD_W'(w_wsat) > w_eff_period) ? w_eff_period[PULSE_W-1:0] : w_wsat;

    // Slot start latches a fresh width; later ticks reuse the latched one
    assign w_width_use = r_start3 ? w_width : r_width;
    assign w_slot_act  = (ACT_W'(r_slot3) < r_active);
    assign w_lines     = (r_tick3 && w_slot_act && (r_cnt3 < PERIOD_W'(w_width_use)))
                         ? (LINES_W'(1) << r_slot3) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_v3;
            if (r_v3 && r_tick3 && r_start3) begin
                r_width <= w_width;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_lines <= w_lines;
            r_out_slot  <= r_slot3;
            r_out_start <= r_tick3 && r_start3;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(OUT_W - OUT_START_BIT - 1)'(0), r_out_start,
                       (CHAN_W)'(r_out_slot), r_out_lines};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // At most one servo line is driven at a time
    a_lines_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> $onehot0(r_out_lines))
        else $error("more than one pulse line high");

    // A driven line always belongs to the reported slot
    a_line_matches_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (r_out_lines != '0)) |-> (r_out_lines == (LINES_W'(1) << r_out_slot)))
        else $error("pulse line does not match current slot");

    // A slot starts on an accepted tick exactly when the tick counter was zero
    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_in_tick && (r_cnt == '0)) |=> (r_v1 && r_tick1 && r_start1))
        else $error("slot start lost in pipeline entry");

    // The latched width never exceeds the counter limit in use at slot start
    a_width_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_v3 && r_tick3 && r_start3) |-> (PERIOD_W'(w_width) <= w_eff_period))
        else $error("pulse width beyond slot period");

endmodule

FILE: sim/multi_servo_pulse_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_servo_pulse_sequencer_tb
// Self-checking bench for the servo pulse sequencer. Ticks and angle requests
// are streamed in while the register settings change between phases. Every
// result is checked against a cycle-free predictor of slot timing and pulse
// width. Both stream sides idle at random, and the result side holds off once.
// ----------------------------------------------------------------------------
module multi_servo_pulse_sequencer_tb;
    import msps_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int STALL_LIMIT = 3000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES = 200;   // long result-side hold-off
    localparam int LAT_CYCLES  = 8;     // settle time after the last result

    typedef struct packed {
        t_req               kind;
        logic [CHAN_W-1:0]  chan;
        logic [ANGLE_W-1:0] deg;
    } t_servo_req;

    typedef struct packed {
        logic [LINES_W-1:0] lines;
        logic [SLOT_W-1:0]  slot;
        logic               start;
    } t_pulse_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;    // [2:0] channel, [10:3] angle
    logic [0:0]        s_tuser;    // [0] req_type
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;    // [7:0] pulse_lines, [10:8] current_slot, [11] slot_start
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    multi_servo_pulse_sequencer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted sequencer state and register copies
    logic [ANGLE_W-1:0]  chan_deg [NUM_CHANNELS];
    logic [SLOT_W-1:0]   slot_idx;
    int                  tick_cnt;
    int                  slot_width;
    logic [ACT_W-1:0]    cfg_active;
    logic [PULSE_W-1:0]  cfg_min;
    logic [PULSE_W-1:0]  cfg_max;
    logic [PERIOD_W-1:0] cfg_period;

    t_servo_req req_q [$];
    t_pulse_out pending_pulses [$];

    // Bookkeeping
    int n_queued, n_accepted, n_ticks, n_angles, n_starts, n_high, n_settings;
    int fails, stall_cycles;
    int idle_pct;
    int hold_seq, hold_seen, hold_left;
    int send_gap, recv_gap;
    logic req_fire;

    // Clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Advance the predicted sequencer by one request and return its result
    function automatic t_pulse_out sequencer_step(t_servo_req r);
        t_pulse_out o;
        int per;
        int w;
        o = '0;
        o.slot = slot_idx;
        if (r.kind == REQ_ANGLE) begin
            chan_deg[r.chan] = (r.deg > FULL_ANGLE) ? ANGLE_W'(FULL_ANGLE) : r.deg;
        end else begin
            per = (cfg_period == 0) ? 1 : int'(cfg_period);
            if (tick_cnt == 0) begin
                // latch the width for this slot at its first tick
                o.start = 1'b1;
                w = int'(cfg_min);
                if (cfg_max > cfg_min)
                    w += (int'(chan_deg[slot_idx]) * (int'(cfg_max) - int'(cfg_min)))
                         / FULL_ANGLE;
                if (w > int'(WIDTH_MAX)) w = int'(WIDTH_MAX);
                if (w > per) w = per;
                slot_width = w;
            end
            if (slot_idx < cfg_active && tick_cnt < slot_width)
                o.lines[slot_idx] = 1'b1;
            tick_cnt++;
            if (tick_cnt >= per) begin
                tick_cnt = 0;
                slot_idx = slot_idx + 1'b1;  // wraps after the last channel
            end
        end
        return o;
    endfunction

    task automatic note_mismatch(string what, int exp_v, int got_v);
        fails++;
        if (fails <= 10)
            $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    endtask

    // Request driver: changes inputs on the falling edge
    always @(negedge i_clk) begin
        t_servo_req nxt;
        if (!s_tvalid || req_fire) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                send_gap = $urandom_range(0, 6);
                s_tvalid <= 1'b0;
            end else if (req_q.size() != 0) begin
                nxt = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.kind;
                s_tdata  <= IN_W'({nxt.deg, nxt.chan});
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side ready: random stalls plus the long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            recv_gap = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_servo_req r;
        t_pulse_out p;
        t_pulse_out want;
        req_fire <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready) begin
            r.kind = t_req'(s_tuser[0]);
            r.chan = s_tdata[CHAN_W-1:0];
            r.deg  = s_tdata[IN_ANGLE_LSB +: ANGLE_W];
            p = sequencer_step(r);
            pending_pulses.push_back(p);
            n_accepted++;
            if (r.kind == REQ_ANGLE) n_angles++;
            else n_ticks++;
            if (p.start) n_starts++;
            if (p.lines != 0) n_high++;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_pulses.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("%0t unexpected result %h", $realtime, m_tdata);
            end else begin
                want = pending_pulses.pop_front();
                if (m_tdata[LINES_W-1:0] !== want.lines)
                    note_mismatch("pulse_lines", want.lines, m_tdata[LINES_W-1:0]);
                if (m_tdata[OUT_SLOT_LSB +: SLOT_W] !== want.slot)
                    note_mismatch("current_slot", want.slot, m_tdata[OUT_SLOT_LSB +: SLOT_W]);
                if (m_tdata[OUT_START_BIT] !== want.start)
                    note_mismatch("slot_start", want.start, m_tdata[OUT_START_BIT]);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("[multi_servo_pulse_sequencer] ERROR");
            $finish;
        end
    end

    task automatic push_req(t_req kind, int chan, int deg);
        t_servo_req r;
        r.kind = kind;
        r.chan = CHAN_W'(chan);
        r.deg  = ANGLE_W'(deg);
        req_q.push_back(r);
        n_queued++;
    endtask

    // Random mix: mostly ticks, some angle updates, some out-of-range angles
    task automatic queue_requests(int n);
        int deg;
        for (int k = 0; k < n; k++) begin
            deg = ($urandom_range(0, 3) == 0) ? $urandom_range(181, 255)
                                              : $urandom_range(0, 180);
            push_req(($urandom_range(0, 99) < 15) ? REQ_ANGLE : REQ_TICK,
                     $urandom_range(0, 7), deg);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (n_accepted != n_queued || pending_pulses.size() != 0);
        repeat (LAT_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_ACTIVE: cfg_active = val[ACT_W-1:0];
            REG_MIN:    cfg_min    = val[PULSE_W-1:0];
            REG_MAX:    cfg_max    = val[PULSE_W-1:0];
            REG_PERIOD: cfg_period = val[PERIOD_W-1:0];
            default:    ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(int act, int lo, int hi, int per);
        write_reg(REG_ACTIVE, DATA_W'(act));
        write_reg(REG_MIN,    DATA_W'(lo));
        write_reg(REG_MAX,    DATA_W'(hi));
        write_reg(REG_PERIOD, DATA_W'(per));
        n_settings++;
    endtask

    task automatic run_phase(int n, int pct);
        idle_pct = pct;
        queue_requests(n);
        wait_drained();
    endtask

    // Stimulus
    initial begin
        int act, lo, hi, per;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        req_fire = 1'b0;
        idle_pct = 0;
        for (int c = 0; c < NUM_CHANNELS; c++) chan_deg[c] = '0;
        slot_idx   = '0;
        tick_cnt   = 0;
        slot_width = 0;
        cfg_active = RST_ACTIVE;
        cfg_min    = RST_MIN;
        cfg_max    = RST_MAX;
        cfg_period = RST_PERIOD;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: angle extremes under reset settings, then a few ticks
        push_req(REQ_ANGLE, 0, 0);
        push_req(REQ_ANGLE, 1, 255);
        push_req(REQ_ANGLE, 2, 180);
        push_req(REQ_ANGLE, 3, 181);
        push_req(REQ_ANGLE, 7, 90);
        push_req(REQ_ANGLE, 4, 1);
        for (int k = 0; k < 4; k++) push_req(REQ_TICK, 7, 255);
        wait_drained();

        // Period dropped below the running count: slot must end on next tick
        apply_settings(8, 2, 10, 2);
        for (int k = 0; k < 6; k++) push_req(REQ_TICK, 0, 0);
        push_req(REQ_ANGLE, 1, 45);  // mid-slot update, used at channel 1's next slot start
        for (int k = 0; k < 8; k++) push_req(REQ_TICK, 0, 0);
        wait_drained();

        // Register extremes: full span, inverted span, zero period, unit period,
        // all-active above eight, longest period
        apply_settings(15, 0, 4095, 20);
        run_phase(80, 10);
        apply_settings(3, 4095, 0, 9);
        run_phase(60, 30);
        apply_settings(0, 0, 0, 0);
        run_phase(50, 0);
        apply_settings(8, 5, 6, 1);
        run_phase(60, 10);
        apply_settings(9, 0, 4095, 65535);
        run_phase(60, 0);

        // Random settings; one phase has the long result-side hold-off
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 3))
                0:       act = 8;
                1:       act = $urandom_range(9, 15);
                default: act = $urandom_range(0, 8);
            endcase
            if ($urandom_range(0, 4) == 0) begin
                lo  = $urandom_range(0, 4095);
                hi  = $urandom_range(0, 4095);
                per = $urandom_range(0, 65535);
            end else begin
                per = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(1, 16);
                lo  = $urandom_range(0, per);
                hi  = $urandom_range(0, 2 * per + 4);
            end
            apply_settings(act, lo, hi, per);
            if (ph == 3) hold_seq++;
            run_phase(90, (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 10 : 35));
        end

        // Closing stretch at full rate with no idling
        apply_settings(8, 1, 12, 14);
        run_phase(150, 0);

        if (pending_pulses.size() != 0) begin
            fails += pending_pulses.size();
            $display("%0d expected results never arrived", pending_pulses.size());
        end
        $display("Ran %0d requests (%0d ticks, %0d angle updates) over %0d register settings;",
                 n_accepted, n_ticks, n_angles, n_settings);
        $display("saw %0d slot starts and %0d ticks with a pulse line high.",
                 n_starts, n_high);
        if (fails == 0) begin
            $display("[multi_servo_pulse_sequencer] OK");
        end else begin
            $display("%0d failures", fails);
            $display("[multi_servo_pulse_sequencer] ERROR");
        end
        $finish;
    end

endmodule
